// File: rtl/utc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_pkg
// Shared types, constants and byte classifiers for the text stream counter.
// ----------------------------------------------------------------------------
package utc_pkg;

   localparam int COUNT_BITS = 48;
   localparam int TAB_STOP   = 8;
   localparam int OUT_BITS   = 48;
   localparam int CP_BITS    = 21;
   localparam int TAB_BITS   = $clog2(TAB_STOP + 3);

   localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
   localparam logic [TAB_BITS-1:0]   SAT_PHASE = TAB_BITS'(CNT_MAX % TAB_STOP);

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic {
      OP_COUNT  = 1'b0,
      OP_FINISH = 1'b1
   } op_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] line_count;
      logic [OUT_BITS-1:0] word_count;
      logic [OUT_BITS-1:0] char_count;
      logic [OUT_BITS-1:0] byte_count;
      logic [OUT_BITS-1:0] max_width;
   } rsp_word_type;

   typedef struct packed {
      logic count;
      logic clear;
   } step_ctl_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
             (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
   endfunction

   function automatic logic is_wide(input logic [CP_BITS-1:0] c);
      return ((c >= 21'h01100) && (c <= 21'h0115F)) ||
             ((c >= 21'h02E80) && (c <= 21'h0303E)) ||
             ((c >= 21'h03041) && (c <= 21'h033FF)) ||
             ((c >= 21'h03400) && (c <= 21'h04DBF)) ||
             ((c >= 21'h04E00) && (c <= 21'h09FFF)) ||
             ((c >= 21'h0A000) && (c <= 21'h0A4CF)) ||
             ((c >= 21'h0AC00) && (c <= 21'h0D7A3)) ||
             ((c >= 21'h0F900) && (c <= 21'h0FAFF)) ||
             ((c >= 21'h0FE30) && (c <= 21'h0FE6F)) ||
             ((c >= 21'h0FF00) && (c <= 21'h0FF60)) ||
             ((c >= 21'h0FFE0) && (c <= 21'h0FFE6)) ||
             ((c >= 21'h20000) && (c <= 21'h3FFFD));
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] x);
      return (x == CNT_MAX) ? x : x + COUNT_BITS'(1);
   endfunction

   function automatic logic [OUT_BITS-1:0] to_out(input logic [COUNT_BITS-1:0] x);
      logic [COUNT_BITS+OUT_BITS-1:0] ext;
      ext = {{OUT_BITS{1'b0}}, x};
      return ext[OUT_BITS-1:0];
   endfunction

endpackage

// File: rtl/utf8_text_stream_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_text_stream_counter
// Line, word, character, byte and widest-line counter over a byte stream.
//
//   channel  dir  handshake              word
//   req      in   req_valid/req_ready    req_word_type (operation, data_byte)
//   rsp      out  rsp_valid/rsp_ready    rsp_word_type (five 48-bit counts)
//   csr      in   csr_valid/csr_ready    csr_data (measure_width)
//
// One word per clock while no finish stalls; a word is registered, then
// counted in the next cycle. A finish word loads the result word and clears
// the counters. Throughput is set by the result register: a finish stalls
// only while a previous result is still waiting. Count words never stall.
// Synchronous reset clears all counters and measure_width; csr is always ready.
// ----------------------------------------------------------------------------
module utf8_text_stream_counter
   import utc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data
);

   logic                  s1_valid_ff, s1_valid_in;
   req_word_type          s1_word_ff, s1_word_in;
   logic                  measure_ff, measure_in;
   logic                  s1_go;
   logic                  slot_free;
   step_ctl_type          ctl;
   logic [COUNT_BITS-1:0] lines, words, chars, bytes, column, widest;

   assign csr_ready  = 1'b1;
   assign measure_in = (csr_valid && csr_ready) ? csr_data : measure_ff;

   assign s1_go     = s1_valid_ff && (s1_word_ff.operation == OP_COUNT || slot_free);
   assign req_ready = !s1_valid_ff || s1_go;

   assign s1_valid_in = (req_valid && req_ready) ? 1'b1 : (s1_valid_ff && !s1_go);
   assign s1_word_in  = (req_valid && req_ready) ? req_word : s1_word_ff;

   assign ctl.count = s1_go && s1_word_ff.operation == OP_COUNT;
   assign ctl.clear = s1_go && s1_word_ff.operation == OP_FINISH;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         measure_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         measure_ff  <= measure_in;
      end
      s1_word_ff <= s1_word_in;
   end

   utc_tally u_tally (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .data_byte (s1_word_ff.data_byte),
      .lines     (lines),
      .words     (words),
      .chars     (chars),
      .bytes     (bytes)
   );

   utc_width u_width (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .measure   (measure_ff),
      .data_byte (s1_word_ff.data_byte),
      .column    (column),
      .widest    (widest)
   );

   utc_result u_result (
      .clock     (clock),
      .reset     (reset),
      .load      (ctl.clear),
      .measure   (measure_ff),
      .lines     (lines),
      .words     (words),
      .chars     (chars),
      .bytes     (bytes),
      .column    (column),
      .widest    (widest),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .slot_free (slot_free)
   );

   a_count_never_stalls: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_word_ff.operation == OP_COUNT |-> s1_go)
      else $error("count word stalled");
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_word_ff))
      else $error("stalled word lost from input stage");
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      !(ctl.count && ctl.clear)) else $error("count and clear in one cycle");

endmodule

// File: rtl/utc_tally.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_tally
// Saturating line, word, character and byte counters for one stream.
// ----------------------------------------------------------------------------
module utc_tally
   import utc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  step_ctl_type          ctl,
   input  logic [7:0]            data_byte,
   output logic [COUNT_BITS-1:0] lines,
   output logic [COUNT_BITS-1:0] words,
   output logic [COUNT_BITS-1:0] chars,
   output logic [COUNT_BITS-1:0] bytes
);

   logic                  in_word_ff, in_word_in;
   logic [COUNT_BITS-1:0] lines_ff, lines_in;
   logic [COUNT_BITS-1:0] words_ff, words_in;
   logic [COUNT_BITS-1:0] chars_ff, chars_in;
   logic [COUNT_BITS-1:0] bytes_ff, bytes_in;

   always_comb begin
      in_word_in = in_word_ff;
      lines_in   = lines_ff;
      words_in   = words_ff;
      chars_in   = chars_ff;
      bytes_in   = bytes_ff;
      if (ctl.clear) begin
         in_word_in = 1'b0;
         lines_in   = '0;
         words_in   = '0;
         chars_in   = '0;
         bytes_in   = '0;
      end else if (ctl.count) begin
         bytes_in = sat_inc(bytes_ff);
         if (data_byte == CH_LF) begin
            lines_in = sat_inc(lines_ff);
         end
         if (is_blank(data_byte)) begin
            in_word_in = 1'b0;
         end else if (!in_word_ff) begin
            in_word_in = 1'b1;
            words_in   = sat_inc(words_ff);
         end
         if (data_byte[7:6] != 2'b10) begin
            chars_in = sat_inc(chars_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff <= 1'b0;
         lines_ff   <= '0;
         words_ff   <= '0;
         chars_ff   <= '0;
         bytes_ff   <= '0;
      end else begin
         in_word_ff <= in_word_in;
         lines_ff   <= lines_in;
         words_ff   <= words_in;
         chars_ff   <= chars_in;
         bytes_ff   <= bytes_in;
      end
   end

   assign lines = lines_ff;
   assign words = words_ff;
   assign chars = chars_ff;
   assign bytes = bytes_ff;

   a_chars_le_bytes: assert property (@(posedge clock) disable iff (reset)
      chars_ff <= bytes_ff) else $error("character count exceeds byte count");
   a_words_le_bytes: assert property (@(posedge clock) disable iff (reset)
      words_ff <= bytes_ff && lines_ff <= bytes_ff)
      else $error("word or line count exceeds byte count");
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> bytes_ff == '0 && words_ff == '0 && !in_word_ff)
      else $error("counters not cleared after finish");

endmodule

// File: rtl/utc_width.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_width
// Display column tracker: tab stops, UTF-8 decode, wide glyphs, widest line.
// ----------------------------------------------------------------------------
module utc_width
   import utc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  step_ctl_type          ctl,
   input  logic                  measure,
   input  logic [7:0]            data_byte,
   output logic [COUNT_BITS-1:0] column,
   output logic [COUNT_BITS-1:0] widest
);

   logic [COUNT_BITS-1:0] col_ff, col_in;
   logic [COUNT_BITS-1:0] widest_ff, widest_in;
   logic [TAB_BITS-1:0]   phase_ff, phase_in;
   logic [CP_BITS-1:0]    cp_ff, cp_in;
   logic [1:0]            pend_ff, pend_in;

   logic                  add_en;
   logic [TAB_BITS-1:0]   add_amt;
   logic [CP_BITS-1:0]    cp_next;
   logic [COUNT_BITS:0]   col_sum;
   logic [TAB_BITS:0]     ph_sum;

   assign cp_next = {cp_ff[CP_BITS-7:0], data_byte[5:0]};

   always_comb begin
      col_in    = col_ff;
      widest_in = widest_ff;
      phase_in  = phase_ff;
      cp_in     = cp_ff;
      pend_in   = pend_ff;
      add_en    = 1'b0;
      add_amt   = '0;
      col_sum   = '0;
      ph_sum    = '0;
      if (ctl.clear) begin
         col_in    = '0;
         widest_in = '0;
         phase_in  = '0;
         cp_in     = '0;
         pend_in   = '0;
      end else if (ctl.count && measure) begin
         priority if (data_byte == CH_LF || data_byte == CH_CR || data_byte == CH_FF) begin
            if (col_ff > widest_ff) begin
               widest_in = col_ff;
            end
            col_in   = '0;
            phase_in = '0;
            pend_in  = '0;
         end else if (data_byte == CH_TAB) begin
            add_en  = 1'b1;
            add_amt = TAB_BITS'(TAB_STOP) - phase_ff;
            pend_in = '0;
         end else if (!data_byte[7]) begin
            add_en  = 1'b1;
            add_amt = TAB_BITS'(1);
            pend_in = '0;
         end else if (data_byte[7:6] == 2'b10) begin
            if (pend_ff != 2'd0) begin
               cp_in   = cp_next;
               pend_in = pend_ff - 2'd1;
               if (pend_ff == 2'd1) begin
                  add_en  = 1'b1;
                  add_amt = is_wide(cp_next) ? TAB_BITS'(2) : TAB_BITS'(1);
               end
            end
         end else if (data_byte[7:5] == 3'b110) begin
            cp_in   = CP_BITS'(data_byte[4:0]);
            pend_in = 2'd1;
         end else if (data_byte[7:4] == 4'b1110) begin
            cp_in   = CP_BITS'(data_byte[3:0]);
            pend_in = 2'd2;
         end else if (data_byte[7:3] == 5'b11110) begin
            cp_in   = CP_BITS'(data_byte[2:0]);
            pend_in = 2'd3;
         end else begin
            add_en  = 1'b1;
            add_amt = TAB_BITS'(1);
            pend_in = '0;
         end
         if (add_en) begin
            col_sum = {1'b0, col_ff} + (COUNT_BITS+1)'(add_amt);
            ph_sum  = {1'b0, phase_ff} + {1'b0, add_amt};
            if (ph_sum >= (TAB_BITS+1)'(TAB_STOP)) begin
               ph_sum = ph_sum - (TAB_BITS+1)'(TAB_STOP);
            end
            if (ph_sum >= (TAB_BITS+1)'(TAB_STOP)) begin
               ph_sum = ph_sum - (TAB_BITS+1)'(TAB_STOP);
            end
            if (col_sum[COUNT_BITS]) begin
               col_in   = CNT_MAX;
               phase_in = SAT_PHASE;
            end else begin
               col_in   = col_sum[COUNT_BITS-1:0];
               phase_in = ph_sum[TAB_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         widest_ff <= '0;
         phase_ff  <= '0;
         cp_ff     <= '0;
         pend_ff   <= '0;
      end else begin
         col_ff    <= col_in;
         widest_ff <= widest_in;
         phase_ff  <= phase_in;
         cp_ff     <= cp_in;
         pend_ff   <= pend_in;
      end
   end

   assign column = col_ff;
   assign widest = widest_ff;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff < TAB_BITS'(TAB_STOP)) else $error("tab phase out of range");
   a_hold_when_off: assert property (@(posedge clock) disable iff (reset)
      !measure && !ctl.clear |=> $stable(col_ff) && $stable(pend_ff) && $stable(widest_ff))
      else $error("width state moved while measurement off");
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> col_ff == '0 && widest_ff == '0 && pend_ff == 2'd0)
      else $error("width state not cleared after finish");

endmodule

// File: rtl/utc_width_dummy_never.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_result
// Result register: holds the finished count word until it is taken.
// ----------------------------------------------------------------------------
module utc_result
   import utc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  measure,
   input  logic [COUNT_BITS-1:0] lines,
   input  logic [COUNT_BITS-1:0] words,
   input  logic [COUNT_BITS-1:0] chars,
   input  logic [COUNT_BITS-1:0] bytes,
   input  logic [COUNT_BITS-1:0] column,
   input  logic [COUNT_BITS-1:0] widest,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_word_type          rsp_word,
   output logic                  slot_free
);

   logic                  valid_ff, valid_in;
   rsp_word_type          word_ff, word_in;
   logic [COUNT_BITS-1:0] final_width;

   assign slot_free   = !valid_ff || rsp_ready;
   assign final_width = (measure && column > widest) ? column : widest;

   always_comb begin
      word_in  = word_ff;
      valid_in = valid_ff && !rsp_ready;
      if (load) begin
         valid_in            = 1'b1;
         word_in.line_count  = to_out(lines);
         word_in.word_count  = to_out(words);
         word_in.char_count  = to_out(chars);
         word_in.byte_count  = to_out(bytes);
         word_in.max_width   = to_out(final_width);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> slot_free) else $error("result overwritten before it was taken");
   a_rise_on_load: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(load)) else $error("result appeared without a finish");

endmodule

// File: tb/utf8_text_stream_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_text_stream_counter_tb
// Self-checking bench for the text stream counter. Byte words and finish
// words go in over req, with random gaps. Each finish result on rsp is
// checked field by field against a cycle-free model of the line, word,
// character, byte and display-width counts. Directed tests cover empty
// streams, tabs, wide and narrow UTF-8 sequences, stray and broken
// sequences, odd code points, all three line breaks and measure_width
// switched mid-stream. Random text then follows, mostly well-formed UTF-8
// with some noise, with width tracking on and off and with and without
// stalls. The 48-bit counters cannot reach saturation in a run this short.
// ----------------------------------------------------------------------------
module utf8_text_stream_counter_tb;
   import utc_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned SETTLE_CYCLES  = 4;

   localparam int unsigned WIDE_LO [12] = '{
      32'h01100, 32'h02E80, 32'h03041, 32'h03400, 32'h04E00, 32'h0A000,
      32'h0AC00, 32'h0F900, 32'h0FE30, 32'h0FF00, 32'h0FFE0, 32'h20000};
   localparam int unsigned WIDE_HI [12] = '{
      32'h0115F, 32'h0303E, 32'h033FF, 32'h04DBF, 32'h09FFF, 32'h0A4CF,
      32'h0D7A3, 32'h0FAFF, 32'h0FE6F, 32'h0FF60, 32'h0FFE6, 32'h3FFFD};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_data;

   // model state
   logic                  width_on;
   logic                  in_word;
   logic [COUNT_BITS-1:0] column;
   logic [COUNT_BITS-1:0] widest;
   logic [COUNT_BITS-1:0] line_tally;
   logic [COUNT_BITS-1:0] word_tally;
   logic [COUNT_BITS-1:0] char_tally;
   logic [COUNT_BITS-1:0] byte_tally;
   logic [CP_BITS-1:0]    cp_partial;
   logic [1:0]            cont_left;

   rsp_word_type expected_totals [$];
   rsp_word_type want;

   bit          idle_on;
   int unsigned words_sent;
   int unsigned results_checked;
   int unsigned mismatches;
   int unsigned quiet_cycles;

   utf8_text_stream_counter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] a,
                                                  input int unsigned b);
      logic [COUNT_BITS:0] total;
      total = {1'b0, a} + b;
      return (total > {1'b0, CNT_MAX}) ? CNT_MAX : total[COUNT_BITS-1:0];
   endfunction

   function automatic bit blank_byte(input logic [7:0] c);
      case (c)
         CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit east_asian_wide(input logic [CP_BITS-1:0] c);
      bit hit = 1'b0;
      for (int i = 0; i < 12; i++)
         if (c >= WIDE_LO[i] && c <= WIDE_HI[i]) hit = 1'b1;
      return hit;
   endfunction

   function automatic void clear_stream_model();
      in_word    = 1'b0;
      column     = '0;
      widest     = '0;
      line_tally = '0;
      word_tally = '0;
      char_tally = '0;
      byte_tally = '0;
      cp_partial = '0;
      cont_left  = '0;
   endfunction

   function automatic void advance_column(input logic [7:0] c);
      if (c == CH_LF || c == CH_CR || c == CH_FF) begin
         if (column > widest) widest = column;
         column    = '0;
         cont_left = '0;
      end else if (c == CH_TAB) begin
         column    = bump(column, TAB_STOP - int'(column % TAB_STOP));
         cont_left = '0;
      end else if (!c[7]) begin
         column    = bump(column, 1);
         cont_left = '0;
      end else if (c[7:6] == 2'b10) begin
         if (cont_left != 0) begin
            cp_partial = {cp_partial[CP_BITS-7:0], c[5:0]};
            cont_left  = cont_left - 2'd1;
            if (cont_left == 0)
               column = bump(column, east_asian_wide(cp_partial) ? 2 : 1);
         end
      end else if (c[7:5] == 3'b110) begin
         cp_partial = CP_BITS'(c[4:0]);
         cont_left  = 2'd1;
      end else if (c[7:4] == 4'b1110) begin
         cp_partial = CP_BITS'(c[3:0]);
         cont_left  = 2'd2;
      end else if (c[7:3] == 5'b11110) begin
         cp_partial = CP_BITS'(c[2:0]);
         cont_left  = 2'd3;
      end else begin
         column    = bump(column, 1);
         cont_left = '0;
      end
   endfunction

   function automatic void count_stream_word(input req_word_type w);
      rsp_word_type totals;
      logic [COUNT_BITS-1:0] top;
      if (w.operation == OP_FINISH) begin
         top = widest;
         if (width_on && column > top) top = column;
         totals.line_count = line_tally;
         totals.word_count = word_tally;
         totals.char_count = char_tally;
         totals.byte_count = byte_tally;
         totals.max_width  = top;
         expected_totals.insert(expected_totals.size(), totals);
         clear_stream_model();
      end else begin
         byte_tally = bump(byte_tally, 1);
         if (w.data_byte == CH_LF) line_tally = bump(line_tally, 1);
         if (blank_byte(w.data_byte)) begin
            in_word = 1'b0;
         end else if (!in_word) begin
            in_word    = 1'b1;
            word_tally = bump(word_tally, 1);
         end
         if (w.data_byte[7:6] != 2'b10) char_tally = bump(char_tally, 1);
         if (width_on) advance_column(w.data_byte);
      end
   endfunction

   function automatic int unsigned pause_len();
      return idle_on ? $urandom_range(0, 5) : 0;
   endfunction

   function automatic void compare_count(input string name, input logic [OUT_BITS-1:0] exp_v,
                                         input logic [OUT_BITS-1:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         mismatches++;
      end
   endfunction

   task automatic send_word(input op_type op, input logic [7:0] b);
      int unsigned gap;
      req_word_type w;
      gap         = pause_len();
      w.operation = op;
      w.data_byte = b;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      count_stream_word(w);
      words_sent++;
   endtask

   // drop valid, drain results, let in-flight byte words land
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_totals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_width_mode(input logic on);
      settle();
      @(negedge clock);
      csr_data  <= on;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      width_on = on;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_bytes(input logic [7:0] seq [$]);
      foreach (seq[i]) send_word(OP_COUNT, seq[i]);
   endtask

   task automatic send_codepoint(input int unsigned cp);
      logic [CP_BITS-1:0] p;
      p = cp[CP_BITS-1:0];
      if (p < 21'h80) begin
         send_word(OP_COUNT, p[7:0]);
      end else if (p < 21'h800) begin
         send_word(OP_COUNT, {3'b110, p[10:6]});
         send_word(OP_COUNT, {2'b10, p[5:0]});
      end else if (p < 21'h10000) begin
         send_word(OP_COUNT, {4'b1110, p[15:12]});
         send_word(OP_COUNT, {2'b10, p[11:6]});
         send_word(OP_COUNT, {2'b10, p[5:0]});
      end else begin
         send_word(OP_COUNT, {5'b11110, p[20:18]});
         send_word(OP_COUNT, {2'b10, p[17:12]});
         send_word(OP_COUNT, {2'b10, p[11:6]});
         send_word(OP_COUNT, {2'b10, p[5:0]});
      end
   endtask

   task automatic send_text_piece();
      int unsigned roll;
      int unsigned len;
      int unsigned k;
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         send_word(OP_COUNT, 8'($urandom_range(8'h21, 8'h7E)));
      end else if (roll < 55) begin
         case ($urandom_range(0, 5))
            0: send_word(OP_COUNT, CH_TAB);
            1: send_word(OP_COUNT, CH_LF);
            2: send_word(OP_COUNT, CH_CR);
            3: send_word(OP_COUNT, CH_FF);
            4: send_word(OP_COUNT, CH_VT);
            default: send_word(OP_COUNT, CH_SPACE);
         endcase
      end else if (roll < 70) begin
         case ($urandom_range(2, 4))
            2: send_codepoint($urandom_range(32'h80, 32'h7FF));
            3: send_codepoint($urandom_range(32'h800, 32'hFFFF));
            default: send_codepoint($urandom_range(32'h10000, 32'h10FFFF));
         endcase
      end else if (roll < 82) begin
         k = $urandom_range(0, 11);
         send_codepoint($urandom_range(WIDE_LO[k], WIDE_HI[k]));
      end else if (roll < 90) begin
         // lead byte with too few continuations; the next piece breaks it
         len = $urandom_range(2, 4);
         case (len)
            2: send_word(OP_COUNT, {3'b110, 5'($urandom)});
            3: send_word(OP_COUNT, {4'b1110, 4'($urandom)});
            default: send_word(OP_COUNT, {5'b11110, 3'($urandom)});
         endcase
         repeat ($urandom_range(0, len - 2)) send_word(OP_COUNT, {2'b10, 6'($urandom)});
      end else begin
         send_word(OP_COUNT, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_plain_counts();
      idle_on = 1'b1;
      send_word(OP_FINISH, 8'h00);
      send_bytes('{8'h00, 8'hFF, CH_LF, 8'h80, CH_SPACE});
      send_word(OP_FINISH, 8'hFF);
   endtask

   task automatic test_width_decode();
      set_width_mode(1'b1);
      send_bytes('{CH_TAB, 8'hE4, 8'hB8, 8'h80, 8'h80});
      send_bytes('{8'hC3, "y", 8'hF0, 8'hA0, 8'h80, 8'h80, CH_CR});
      send_bytes('{8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF8});
      send_bytes('{8'hE4, CH_FF, "z", CH_VT});
      send_word(OP_FINISH, 8'h5A);
   endtask

   task automatic test_width_switch();
      send_bytes('{"a", "b"});
      set_width_mode(1'b0);
      send_bytes('{CH_TAB, "c", CH_LF});
      set_width_mode(1'b1);
      send_word(OP_COUNT, "d");
      send_word(OP_FINISH, 8'hA5);
      send_bytes('{"a", "b", "c", CH_CR, "d", "e", "f", "g"});
      set_width_mode(1'b0);
      send_word(OP_FINISH, 8'h00);
   endtask

   task automatic test_random_text(input logic mode, input bit idling, input int unsigned budget);
      int unsigned start;
      set_width_mode(mode);
      idle_on = idling;
      start   = words_sent;
      while (words_sent - start < budget) begin
         send_text_piece();
         if ($urandom_range(0, 9) == 0) send_word(OP_FINISH, 8'($urandom));
      end
      send_word(OP_FINISH, 8'($urandom));
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_totals.size() == 0) begin
            $error("result word with no finish pending");
            mismatches++;
         end else begin
            want = expected_totals.pop_front();
            compare_count("line_count", want.line_count, rsp_word.line_count);
            compare_count("word_count", want.word_count, rsp_word.word_count);
            compare_count("char_count", want.char_count, rsp_word.char_count);
            compare_count("byte_count", want.byte_count, rsp_word.byte_count);
            compare_count("max_width", want.max_width, rsp_word.max_width);
            results_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("utf8_text_stream_counter_tb: done, errors");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin : responder
      int unsigned stall;
      rsp_ready = 1'b0;
      do @(negedge clock); while (reset);
      rsp_ready <= 1'b1;
      forever begin
         stall = pause_len();
         if (stall != 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
            repeat (stall) @(negedge clock);
            rsp_ready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin
      req_valid       = 1'b0;
      req_word        = '0;
      csr_valid       = 1'b0;
      csr_data        = 1'b0;
      idle_on         = 1'b0;
      words_sent      = 0;
      width_on        = 1'b0;
      clear_stream_model();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_plain_counts();
      test_width_decode();
      test_width_switch();
      test_random_text(1'b1, 1'b1, 150);
      test_random_text(1'b0, 1'b0, 100);
      test_random_text(1'b1, 1'b0, 100);
      test_random_text(1'b1, 1'b1, 150);
      settle();

      $display("run covered %0d stream words and %0d finish results checked,", words_sent,
               results_checked);
      $display("width tracking on, off and switched mid-stream, with and without stalls");
      if (mismatches == 0)
         $display("utf8_text_stream_counter_tb: done, clean");
      else
         $display("utf8_text_stream_counter_tb: done, errors");
      $finish;
   end

endmodule

// File: sim.f
rtl/utc_pkg.sv
rtl/utc_tally.sv
rtl/utc_width.sv
rtl/utc_width_dummy_never.sv
rtl/utf8_text_stream_counter.sv
tb/utf8_text_stream_counter_tb.sv
